[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define TOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every edge, reset included
`define TOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TOC_ASSERT(lbl, prop, msg)
`define TOC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/toc_pkg.sv]
`default_nettype none

package toc_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_SOURCE  = 2'd0,
    OP_TRANSIT = 2'd1,
    OP_EGRESS  = 2'd2
  } op_e;

  // protocol codes, anything else counts as other ip
  typedef enum logic [1:0] {
    PROTO_OTHER = 2'd0,
    PROTO_TCP   = 2'd1,
    PROTO_UDP   = 2'd2
  } proto_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_NODE_ID       = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD = 1'b1;

  // option and record layout
  localparam logic [7:0]  OPT_KIND      = 8'd254;
  localparam logic [15:0] OPT_EXID      = 16'h0000;
  localparam logic [3:0]  MAX_DOFF      = 4'd15;
  localparam logic [3:0]  MIN_DOFF      = 4'd5;
  localparam logic [3:0]  SRC_MAX_DOFF  = 4'd13;
  localparam logic [3:0]  SRC_GROW      = 4'd8;
  localparam logic [3:0]  TRANSIT_GROW  = 4'd4;
  localparam logic [3:0]  SRC_DGROW     = 4'd2;
  localparam logic [3:0]  TRANSIT_DGROW = 4'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  protocol;
    logic [15:0] ip_total_len;
    logic [15:0] ip_checksum;
    logic [3:0]  ip_header_words;
    logic [15:0] tcp_checksum;
    logic [15:0] tcp_offset_flags;
    logic [7:0]  option_length;
    logic [7:0]  record_node;
    logic [23:0] record_stamp;
    logic [23:0] now_us;
    logic [63:0] now_ns;
  } toc_in_t;

  typedef struct packed {
    logic        modified;
    logic [15:0] new_ip_total_len;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_tcp_checksum;
    logic [15:0] new_tcp_offset_flags;
    logic [7:0]  new_option_length;
    logic [7:0]  out_record_node;
    logic [23:0] out_record_stamp;
  } toc_out_t;

endpackage

`default_nettype wire

[src/toc_in_if.sv]
`default_nettype none

interface toc_in_if;
  import toc_pkg::*;

  logic    valid;
  logic    ready;
  toc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/toc_out_if.sv]
`default_nettype none

interface toc_out_if;
  import toc_pkg::*;

  logic     valid;
  logic     ready;
  toc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/toc_calc.sv]
`default_nettype none

module toc_calc (
  input  toc_pkg::toc_in_t  item_i,
  input  logic [7:0]        node_id_i,
  input  logic [31:0]       sample_period_i,
  input  logic [63:0]       last_sample_i,
  output toc_pkg::toc_out_t result_o,
  output logic              sample_take_o
);
  import toc_pkg::*;

  // end-around fold of a ones-complement sum, then invert
  function automatic logic [15:0] fold_not(input logic [19:0] s);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    s2 = s1[15:0] + {15'b0, s1[16]};
    return ~s2;
  endfunction

  logic        is_src, is_tr, is_eg, tcp, udp;
  logic [3:0]  doff;
  logic [63:0] period_end;
  logic        gate;
  logic        src_mod, tr_mod, eg_mod, grow_any;
  logic [3:0]  grow, dgrow;
  logic [15:0] new_len;
  logic [7:0]  new_opt;
  logic [7:0]  rec_node;
  logic [23:0] rec_stamp, elapsed;
  logic [15:0] new_offw, hb, l1, l2;
  logic [15:0] w1, w2, w1_old, w2_old, k_new, k_old;
  logic [19:0] ip_sum, grow_sum, eg_sum;
  logic [15:0] ip_cs, grow_cs, eg_cs;

  // decode
  assign is_src = (item_i.operation == OP_SOURCE);
  assign is_tr  = (item_i.operation == OP_TRANSIT);
  assign is_eg  = (item_i.operation == OP_EGRESS);
  assign tcp    = (item_i.protocol == PROTO_TCP);
  assign udp    = (item_i.protocol == PROTO_UDP);
  assign doff   = item_i.tcp_offset_flags[15:12];

  // sampling gate, the sum wraps at 64 bits
  assign period_end = last_sample_i + {32'b0, sample_period_i};
  assign gate       = (item_i.now_ns >= period_end);

  assign sample_take_o = is_src && gate && !(tcp && (doff > SRC_MAX_DOFF));
  assign src_mod  = sample_take_o && (tcp || udp);
  assign tr_mod   = is_tr && (udp || (tcp && (doff > MIN_DOFF) && (doff < MAX_DOFF)));
  assign eg_mod   = is_eg && (udp || (tcp && (doff > MIN_DOFF)));
  assign grow_any = src_mod || tr_mod;
  assign grow     = src_mod ? SRC_GROW : TRANSIT_GROW;
  assign dgrow    = src_mod ? SRC_DGROW : TRANSIT_DGROW;

  // lengths and record
  assign new_len = item_i.ip_total_len + {12'b0, grow};
  assign new_opt = src_mod ? {4'b0, SRC_GROW}
                 : (tr_mod ? item_i.option_length + {4'b0, TRANSIT_GROW}
                           : item_i.option_length);
  assign elapsed = item_i.now_us - item_i.record_stamp;

  always_comb begin
    if (grow_any) begin
      rec_node  = node_id_i;
      rec_stamp = item_i.now_us;
    end else if (eg_mod) begin
      rec_node  = item_i.record_node;
      rec_stamp = elapsed;
    end else begin
      rec_node  = 8'd0;
      rec_stamp = 24'd0;
    end
  end

  // words on the wire
  assign w1     = {rec_node, rec_stamp[7:0]};
  assign w2     = {rec_stamp[15:8], rec_stamp[23:16]};
  assign w1_old = {item_i.record_node, item_i.record_stamp[7:0]};
  assign w2_old = {item_i.record_stamp[15:8], item_i.record_stamp[23:16]};
  assign k_new  = {OPT_KIND, new_opt};
  assign k_old  = {OPT_KIND, item_i.option_length};
  assign new_offw = {doff + dgrow, item_i.tcp_offset_flags[11:0]};
  assign hb     = {10'b0, item_i.ip_header_words, 2'b0};
  assign l1     = item_i.ip_total_len - hb;
  assign l2     = new_len - hb;

  // ip header checksum update
  assign ip_sum = {4'b0, ~item_i.ip_checksum} + {4'b0, ~item_i.ip_total_len}
                + {4'b0, new_len};
  assign ip_cs  = fold_not(ip_sum);

  // tcp checksum when the header grows, all updates in one folded sum
  always_comb begin
    grow_sum = {4'b0, ~item_i.tcp_checksum} + {4'b0, ~item_i.tcp_offset_flags}
             + {4'b0, new_offw} + {4'b0, ~l1} + {4'b0, l2}
             + {4'b0, w1} + {4'b0, w2};
    if (src_mod) begin
      grow_sum = grow_sum + {4'b0, k_new} + {4'b0, OPT_EXID};
    end else begin
      grow_sum = grow_sum + {4'b0, ~k_old} + {4'b0, k_new};
    end
  end
  assign grow_cs = fold_not(grow_sum);

  // tcp checksum when the egress record is rewritten in place
  assign eg_sum = {4'b0, ~item_i.tcp_checksum} + {4'b0, ~w1_old} + {4'b0, ~w2_old}
                + {4'b0, w1} + {4'b0, w2};
  assign eg_cs  = fold_not(eg_sum);

  // result selection
  always_comb begin
    result_o.modified             = src_mod || tr_mod || eg_mod;
    result_o.new_ip_total_len     = grow_any ? new_len : item_i.ip_total_len;
    result_o.new_ip_checksum      = grow_any ? ip_cs : item_i.ip_checksum;
    result_o.new_tcp_offset_flags = (grow_any && tcp) ? new_offw : item_i.tcp_offset_flags;
    result_o.new_option_length    = new_opt;
    result_o.out_record_node      = rec_node;
    result_o.out_record_stamp     = rec_stamp;
    if (grow_any && tcp) begin
      result_o.new_tcp_checksum = grow_cs;
    end else if (eg_mod && tcp) begin
      result_o.new_tcp_checksum = eg_cs;
    end else begin
      result_o.new_tcp_checksum = item_i.tcp_checksum;
    end
  end

endmodule

`default_nettype wire

[src/telemetry_option_checksum_rewrite.sv]
`default_nettype none
// channel   dir   payload     transfer
// in_i      in    toc_in_t    in_i.valid && in_i.ready
// out_o     out   toc_out_t   out_o.valid && out_o.ready
// cfg       in    index, 32b  cfg_we_i high at the clock edge
//
// one item per cycle while the output is not stalled; a result passes the input
// register, then the result register, and transfers from the result register.
// the last-sample time is updated as an item leaves the input register, so
// the next item already sees it. reset clears both valid flags, the
// configuration registers and the last-sample time. a stalled output holds
// the result register and then the input register; no item is dropped.

module telemetry_option_checksum_rewrite (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [toc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [toc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  toc_in_if.sink                        in_i,
  toc_out_if.source                     out_o
);
  import toc_pkg::*;

  logic [7:0]  node_id_q;
  logic [31:0] sample_period_q;
  logic [63:0] last_sample_q;
  logic        s1_valid_q, out_valid_q;
  toc_in_t     s1_q;
  toc_out_t    out_q;
  toc_out_t    calc_result;
  logic        sample_take;
  logic        s1_adv, s1_fire, in_fire;

  // handshake
  assign s1_adv   = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q       <= 8'd0;
      sample_period_q <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NODE_ID:       node_id_q       <= cfg_wdata_i[7:0];
        CFG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // rewrite logic
  toc_calc u_calc (
    .item_i          (s1_q),
    .node_id_i       (node_id_q),
    .sample_period_i (sample_period_q),
    .last_sample_i   (last_sample_q),
    .result_o        (calc_result),
    .sample_take_o   (sample_take)
  );

  // sampling state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q <= 64'd0;
    end else if (s1_fire && sample_take) begin
      last_sample_q <= s1_q.now_ns;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.data;
    end
    if (s1_fire) begin
      out_q <= calc_result;
    end
  end

  // assertions
  `include "assert_macros.svh"

  `TOC_ASSERT(a_fire_fills_out, s1_fire |=> out_valid_q, "result register not filled")
  `TOC_ASSERT(a_stall_cause, !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready), "input stalled without a full pipe")
  `TOC_ASSERT(a_sample_hold, !(s1_fire && sample_take) |=> $stable(last_sample_q), "sample time moved without a source transfer")
  `TOC_ASSERT(a_pass_no_record, (out_valid_q && !out_q.modified) |-> (out_q.out_record_node == 8'd0 && out_q.out_record_stamp == 24'd0), "unmodified result carries a record")
  `TOC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!s1_valid_q && !out_valid_q), "valid set during reset")

endmodule

`default_nettype wire

[sim/telemetry_option_checksum_rewrite_test.sv]
module telemetry_option_checksum_rewrite_test;
  import toc_pkg::*;

  // codes that the package enums leave out
  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [1:0] PROTO_RSVD = 2'd3;

  // option layout as seen on the wire
  localparam logic [7:0]  KIND_BYTE       = 8'd254;
  localparam logic [15:0] OPTION_ID_WORD  = 16'h0000;
  localparam logic [7:0]  SOURCE_OPT_LEN  = 8'd8;
  localparam logic [7:0]  RECORD_BYTES    = 8'd4;
  localparam logic [15:0] SOURCE_GROW     = 16'd8;
  localparam logic [15:0] TRANSIT_GROW    = 16'd4;
  localparam logic [3:0]  SOURCE_DGROW    = 4'd2;
  localparam logic [3:0]  TRANSIT_DGROW   = 4'd1;
  localparam logic [3:0]  SOURCE_DOFF_TOP = 4'd13;
  localparam logic [3:0]  DOFF_FLOOR      = 4'd5;
  localparam logic [3:0]  DOFF_CEIL       = 4'd15;

  // checksum update terms that add nothing
  localparam logic [15:0] NO_OLD_WORD = 16'hffff;
  localparam logic [15:0] NO_NEW_WORD = 16'h0000;

  localparam int unsigned PHASE_ITEMS  = 420;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_MAX   = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  toc_in_if  pkt_if ();
  toc_out_if res_if ();

  telemetry_option_checksum_rewrite dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (pkt_if),
    .out_o       (res_if)
  );

  // shadow of the block's registers and sampling state
  logic [7:0]  node_cfg = '0;
  logic [31:0] period_cfg = '0;
  logic [63:0] last_sample_ns = '0;
  logic [63:0] ns_clock = '0;

  toc_out_t    expected_rewrites[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned report_count = 0;
  int unsigned cycle_count = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("telemetry_option_checksum_rewrite_test: errors");
    $finish;
  end

  // ones-complement incremental update: drop two old words, add two new ones
  function automatic logic [15:0] csum_adjust(input logic [15:0] csum, input logic [15:0] old1,
                                              input logic [15:0] old2, input logic [15:0] new1,
                                              input logic [15:0] new2);
    logic [15:0] inv_c, inv_o1, inv_o2;
    logic [31:0] acc;
    inv_c  = ~csum;
    inv_o1 = ~old1;
    inv_o2 = ~old2;
    acc = {16'h0, inv_c} + {16'h0, inv_o1} + {16'h0, inv_o2} + {16'h0, new1} + {16'h0, new2};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    acc = acc + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // record words: node and stamp low byte, then stamp middle and high bytes
  function automatic logic [15:0] record_word_lo(input logic [7:0] node, input logic [23:0] stamp);
    return {node, stamp[7:0]};
  endfunction

  function automatic logic [15:0] record_word_hi(input logic [23:0] stamp);
    return {stamp[15:8], stamp[23:16]};
  endfunction

  // expected header rewrite for one packet, advances the sampling state
  function automatic toc_out_t predict_rewrite(input toc_in_t pkt);
    toc_out_t    r;
    logic [3:0]  doff;
    logic [3:0]  dgrow;
    logic [15:0] grow;
    logic [15:0] hdr_bytes;
    logic [63:0] gate_ns;
    logic        is_tcp;
    logic        is_udp;
    doff    = pkt.tcp_offset_flags[15:12];
    is_tcp  = (pkt.protocol == PROTO_TCP);
    is_udp  = (pkt.protocol == PROTO_UDP);
    grow    = '0;
    dgrow   = '0;
    gate_ns = last_sample_ns + {32'h0, period_cfg};
    r.modified             = 1'b0;
    r.new_ip_total_len     = pkt.ip_total_len;
    r.new_ip_checksum      = pkt.ip_checksum;
    r.new_tcp_checksum     = pkt.tcp_checksum;
    r.new_tcp_offset_flags = pkt.tcp_offset_flags;
    r.new_option_length    = pkt.option_length;
    r.out_record_node      = '0;
    r.out_record_stamp     = '0;

    // decide what the packet gets
    case (pkt.operation)
      OP_SOURCE: begin
        if (pkt.now_ns >= gate_ns && !(is_tcp && doff > SOURCE_DOFF_TOP)) begin
          last_sample_ns = pkt.now_ns;
          if (is_tcp || is_udp) begin
            r.modified          = 1'b1;
            grow                = SOURCE_GROW;
            dgrow               = SOURCE_DGROW;
            r.new_option_length = SOURCE_OPT_LEN;
            r.out_record_node   = node_cfg;
            r.out_record_stamp  = pkt.now_us;
          end
        end
      end
      OP_TRANSIT: begin
        if (is_udp || (is_tcp && doff > DOFF_FLOOR && doff < DOFF_CEIL)) begin
          r.modified          = 1'b1;
          grow                = TRANSIT_GROW;
          dgrow               = TRANSIT_DGROW;
          r.new_option_length = pkt.option_length + RECORD_BYTES;
          r.out_record_node   = node_cfg;
          r.out_record_stamp  = pkt.now_us;
        end
      end
      OP_EGRESS: begin
        if (is_udp || (is_tcp && doff > DOFF_FLOOR)) begin
          r.modified         = 1'b1;
          r.out_record_node  = pkt.record_node;
          r.out_record_stamp = pkt.now_us - pkt.record_stamp;
          if (is_tcp) begin
            r.new_tcp_checksum = csum_adjust(pkt.tcp_checksum,
                record_word_lo(pkt.record_node, pkt.record_stamp),
                record_word_hi(pkt.record_stamp),
                record_word_lo(pkt.record_node, r.out_record_stamp),
                record_word_hi(r.out_record_stamp));
          end
        end
      end
      default: ;
    endcase

    // length growth and the checksums it touches
    if (grow != '0) begin
      r.new_ip_total_len = pkt.ip_total_len + grow;
      r.new_ip_checksum  = csum_adjust(pkt.ip_checksum, pkt.ip_total_len, NO_OLD_WORD,
                                       r.new_ip_total_len, NO_NEW_WORD);
      if (is_tcp) begin
        hdr_bytes              = {10'h0, pkt.ip_header_words, 2'b00};
        r.new_tcp_offset_flags = {doff + dgrow, pkt.tcp_offset_flags[11:0]};
        r.new_tcp_checksum     = csum_adjust(pkt.tcp_checksum, pkt.tcp_offset_flags,
                                             NO_OLD_WORD, r.new_tcp_offset_flags, NO_NEW_WORD);
        r.new_tcp_checksum     = csum_adjust(r.new_tcp_checksum, pkt.ip_total_len - hdr_bytes,
                                             NO_OLD_WORD, r.new_ip_total_len - hdr_bytes,
                                             NO_NEW_WORD);
        if (pkt.operation == OP_SOURCE) begin
          r.new_tcp_checksum = csum_adjust(r.new_tcp_checksum, NO_OLD_WORD, NO_OLD_WORD,
                                           {KIND_BYTE, r.new_option_length}, OPTION_ID_WORD);
        end
        r.new_tcp_checksum = csum_adjust(r.new_tcp_checksum, NO_OLD_WORD, NO_OLD_WORD,
                                         record_word_lo(r.out_record_node, r.out_record_stamp),
                                         record_word_hi(r.out_record_stamp));
        if (pkt.operation == OP_TRANSIT) begin
          r.new_tcp_checksum = csum_adjust(r.new_tcp_checksum, {KIND_BYTE, pkt.option_length},
                                           NO_OLD_WORD, {KIND_BYTE, r.new_option_length},
                                           NO_NEW_WORD);
        end
      end
    end
    return r;
  endfunction

  // compare one result transfer with the oldest expected rewrite
  task automatic check_result(input toc_out_t got);
    toc_out_t want;
    if (expected_rewrites.size() == 0) begin
      error_count++;
      if (report_count < REPORT_MAX) begin
        report_count++;
        $display("unexpected result at cycle %0d: %h", cycle_count, got);
      end
    end else begin
      want = expected_rewrites.pop_front();
      if (got.modified !== want.modified || got.new_ip_total_len !== want.new_ip_total_len ||
          got.new_ip_checksum !== want.new_ip_checksum ||
          got.new_tcp_checksum !== want.new_tcp_checksum ||
          got.new_tcp_offset_flags !== want.new_tcp_offset_flags ||
          got.new_option_length !== want.new_option_length ||
          got.out_record_node !== want.out_record_node ||
          got.out_record_stamp !== want.out_record_stamp) begin
        error_count++;
        if (report_count < REPORT_MAX) begin
          report_count++;
          $display("mismatch at cycle %0d", cycle_count);
          $display("  expected mod=%b len=%h ipcs=%h tcs=%h offw=%h opt=%h node=%h stamp=%h",
                   want.modified, want.new_ip_total_len, want.new_ip_checksum,
                   want.new_tcp_checksum, want.new_tcp_offset_flags, want.new_option_length,
                   want.out_record_node, want.out_record_stamp);
          $display("  actual   mod=%b len=%h ipcs=%h tcs=%h offw=%h opt=%h node=%h stamp=%h",
                   got.modified, got.new_ip_total_len, got.new_ip_checksum,
                   got.new_tcp_checksum, got.new_tcp_offset_flags, got.new_option_length,
                   got.out_record_node, got.out_record_stamp);
        end
      end
    end
  endtask

  // result side: random stalls, checked on each transfer
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      check_result(res_if.data);
    end
  end

  // register write, taken at the next rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_NODE_ID) begin
      node_cfg = value[7:0];
    end else begin
      period_cfg = value;
    end
  endtask

  // one packet header, with random idle cycles ahead of it
  task automatic send_item(input toc_in_t pkt);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pkt_if.valid = 1'b1;
    pkt_if.data  = pkt;
    do @(posedge clk_i); while (!pkt_if.ready);
    expected_rewrites.push_back(predict_rewrite(pkt));
    @(negedge clk_i);
  endtask

  // hold the input until every result is back
  task automatic wait_drained();
    pkt_if.valid = 1'b0;
    while (expected_rewrites.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // well-formed header with random checksums and record
  function automatic toc_in_t base_packet(input logic [1:0] op, input logic [1:0] proto,
                                          input logic [3:0] doff);
    toc_in_t pkt;
    pkt.operation        = op;
    pkt.protocol         = proto;
    pkt.ip_total_len     = 16'd60;
    pkt.ip_checksum      = 16'($urandom);
    pkt.ip_header_words  = 4'd5;
    pkt.tcp_checksum     = 16'($urandom);
    pkt.tcp_offset_flags = {doff, 12'($urandom)};
    pkt.option_length    = SOURCE_OPT_LEN;
    pkt.record_node      = 8'($urandom);
    pkt.record_stamp     = 24'($urandom);
    pkt.now_us           = 24'($urandom);
    ns_clock             = ns_clock + 64'd1;
    pkt.now_ns           = ns_clock;
    return pkt;
  endfunction

  // random header: mostly plausible traffic, some noise
  function automatic toc_in_t random_packet();
    toc_in_t     pkt;
    int unsigned pick;
    logic [3:0]  doff;
    logic [3:0]  ihl;
    pick = $urandom_range(99);
    doff = ($urandom_range(9) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
    ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    pkt  = base_packet((pick < 32) ? OP_SOURCE : (pick < 64) ? OP_TRANSIT :
                       (pick < 96) ? OP_EGRESS : OP_NONE, PROTO_OTHER, doff);
    pick = $urandom_range(99);
    pkt.protocol = (pick < 50) ? PROTO_TCP : (pick < 85) ? PROTO_UDP :
                   (pick < 95) ? PROTO_OTHER : PROTO_RSVD;
    pkt.ip_header_words = ihl;
    if ($urandom_range(9) == 0) begin
      pkt.ip_total_len = 16'($urandom);
    end else begin
      pkt.ip_total_len = {10'h0, ihl, 2'b00} + {10'h0, doff, 2'b00} +
                         16'($urandom_range(0, 1460));
    end
    if ($urandom_range(9) == 0) begin
      pkt.option_length = 8'($urandom);
    end else begin
      pkt.option_length = 8'(8 + 4 * $urandom_range(0, 8));
    end
    // packet time: mostly forward steps near the period, sometimes jumps
    case ($urandom_range(19))
      0: ns_clock = {$urandom, $urandom};
      1: ns_clock = ns_clock - 64'($urandom_range(1, 5000));
      default: ns_clock = ns_clock + ({$urandom, $urandom} % ({32'h0, period_cfg} * 64'd2 + 64'd2));
    endcase
    pkt.now_ns = ns_clock;
    return pkt;
  endfunction

  // each operation and protocol, the offset limits, wraps and unknown codes
  task automatic test_rewrite_cases();
    toc_in_t pkt;
    write_reg(CFG_NODE_ID, 32'h0000_00a5);
    write_reg(CFG_SAMPLE_PERIOD, 32'h0);
    send_idle_pct = 0;
    recv_idle_pct = 30;

    // source insert
    pkt = base_packet(OP_SOURCE, PROTO_TCP, 4'd5);
    pkt.ip_total_len = 16'hffff;
    pkt.ip_checksum  = 16'h0000;
    pkt.tcp_checksum = 16'hffff;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_TCP, 4'd13);
    pkt.ip_total_len = 16'h0000;
    pkt.ip_checksum  = 16'hffff;
    pkt.tcp_checksum = 16'h0000;
    send_item(pkt);
    send_item(base_packet(OP_SOURCE, PROTO_TCP, 4'd14));
    send_item(base_packet(OP_SOURCE, PROTO_TCP, 4'd0));
    send_item(base_packet(OP_SOURCE, PROTO_UDP, 4'd5));
    send_item(base_packet(OP_SOURCE, PROTO_OTHER, 4'd5));
    send_item(base_packet(OP_SOURCE, PROTO_RSVD, 4'd5));

    // transit append, offset at the bottom, the top and full
    send_item(base_packet(OP_TRANSIT, PROTO_TCP, 4'd5));
    pkt = base_packet(OP_TRANSIT, PROTO_TCP, 4'd6);
    pkt.option_length   = 8'hfe;
    pkt.ip_header_words = 4'd15;
    send_item(pkt);
    send_item(base_packet(OP_TRANSIT, PROTO_TCP, 4'd14));
    send_item(base_packet(OP_TRANSIT, PROTO_TCP, 4'd15));
    pkt = base_packet(OP_TRANSIT, PROTO_UDP, 4'd5);
    pkt.ip_total_len = 16'hfffe;
    send_item(pkt);
    send_item(base_packet(OP_TRANSIT, PROTO_OTHER, 4'd8));

    // egress, with and without stamp wrap
    send_item(base_packet(OP_EGRESS, PROTO_TCP, 4'd5));
    pkt = base_packet(OP_EGRESS, PROTO_TCP, 4'd6);
    pkt.now_us       = 24'h000000;
    pkt.record_stamp = 24'hffffff;
    pkt.record_node  = 8'hff;
    send_item(pkt);
    pkt = base_packet(OP_EGRESS, PROTO_TCP, 4'd15);
    pkt.now_us       = 24'hffffff;
    pkt.record_stamp = 24'h000000;
    pkt.record_node  = 8'h00;
    send_item(pkt);
    pkt = base_packet(OP_EGRESS, PROTO_UDP, 4'd5);
    pkt.now_us = pkt.record_stamp;
    send_item(pkt);
    send_item(base_packet(OP_EGRESS, PROTO_OTHER, 4'd8));

    // unknown operation
    send_item(base_packet(OP_NONE, PROTO_TCP, 4'd8));
  endtask

  // sampling gate: period edge, sum wrap, skipped tcp leaves the state alone
  task automatic test_sample_gate();
    toc_in_t     pkt;
    logic [63:0] t0;
    wait_drained();
    write_reg(CFG_NODE_ID, 32'h0000_003c);
    write_reg(CFG_SAMPLE_PERIOD, 32'd1000);
    t0 = ns_clock + 64'd5000;
    pkt = base_packet(OP_SOURCE, PROTO_UDP, 4'd5);
    pkt.now_ns = t0;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_UDP, 4'd5);
    pkt.now_ns = t0 + 64'd999;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_UDP, 4'd5);
    pkt.now_ns = t0 + 64'd1000;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_OTHER, 4'd5);
    pkt.now_ns = 64'hffff_ffff_ffff_fff0;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_UDP, 4'd5);
    pkt.now_ns = 64'd100;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_UDP, 4'd5);
    pkt.now_ns = 64'd984;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_TCP, 4'd14);
    pkt.now_ns = 64'd1990;
    send_item(pkt);
    pkt = base_packet(OP_SOURCE, PROTO_UDP, 4'd5);
    pkt.now_ns = 64'd1985;
    send_item(pkt);
    ns_clock = 64'd2000;
  endtask

  // random traffic under one register setting and one idle pattern
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [7:0] node, input logic [31:0] period);
    wait_drained();
    write_reg(CFG_NODE_ID, {24'h0, node});
    write_reg(CFG_SAMPLE_PERIOD, period);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // hold off halfway until the pipeline is empty
      if (n == PHASE_ITEMS / 2) begin
        wait_drained();
      end
      send_item(random_packet());
    end
  endtask

  // sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_NODE_ID;
    cfg_wdata_i  = '0;
    pkt_if.valid = 1'b0;
    pkt_if.data  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_rewrite_cases();
    test_sample_gate();
    test_random_traffic(13, 66, 8'($urandom), 32'h0000_0000);
    test_random_traffic(66, 13, 8'hff, 32'hffff_ffff);
    test_random_traffic(0, 0, 8'h00, 32'($urandom_range(1, 100000)));
    wait_drained();

    if (error_count == 0 && expected_rewrites.size() == 0) begin
      $display("telemetry_option_checksum_rewrite_test: clean");
    end else begin
      $display("telemetry_option_checksum_rewrite_test: errors");
    end
    $finish;
  end

endmodule
